[design/assert_macros.svh]
// Assertion helpers shared by the checker RTL.
// Each expects signals named clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define AST_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define AST_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[design/sefc_pkg.sv]
`default_nettype none

package sefc_pkg;

  // Frame markers
  localparam logic [7:0] MARK_START = 8'h02;
  localparam logic [7:0] MARK_END   = 8'h03;

  // Parser phase
  typedef enum logic [2:0] {
    PH_STX  = 3'd0,
    PH_CMD  = 3'd1,
    PH_LENH = 3'd2,
    PH_LENL = 3'd3,
    PH_PAY  = 3'd4,
    PH_SUM  = 3'd5,
    PH_ETX  = 3'd6,
    PH_DROP = 3'd7
  } phase_t;

  // Frame status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CSUM  = 2'd1,
    ST_MARK  = 2'd2,
    ST_SHORT = 2'd3
  } status_t;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // One result beat
  typedef struct packed {
    logic        kind;
    logic [7:0]  frame_cmd;
    logic [7:0]  payload_byte;
    status_t     status;
    logic        last;
  } result_t;

  // Results produced by one parsed byte; item1 only used when item0 is valid
  typedef struct packed {
    logic    vld0;
    logic    vld1;
    result_t item0;
    result_t item1;
  } push_t;

endpackage

`default_nettype wire

[design/sefc_ifs.sv]
`default_nettype none

// Received byte channel
interface sefc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       chunk_end;

  modport source (output valid, output rx_byte, output chunk_end, input ready);
  modport sink   (input valid, input rx_byte, input chunk_end, output ready);
endinterface

// Result channel
interface sefc_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] frame_cmd;
  logic [7:0] payload_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output kind, output frame_cmd, output payload_byte,
                  output status, output last, input ready);
  modport sink   (input valid, input kind, input frame_cmd, input payload_byte,
                  input status, input last, output ready);
endinterface

`default_nettype wire

[design/stx_etx_frame_checker_core.sv]
// Channel  Dir  Beat contents
// -------  ---  ---------------------------------------------------
// in_ch    in   rx_byte, chunk_end (one received byte)
// out_ch   out  kind, frame_cmd, payload_byte, status, last
//
// One byte is taken per clock while in_ch.ready is high; a taken byte waits in
// the input register, then the parser writes its results into the queue.
// The queue drains one result per clock while out_ch.ready is high. A payload
// byte that ends a chunk makes two results, a payload beat then a status beat.
// in_ch.ready drops while a byte waits in the input register and the queue
// has fewer than two free slots; out_ch stalls only back up into the queue.
// Reset is synchronous (rst_n low for one clock) and needs no clearing pass.
`default_nettype none

module stx_etx_frame_checker_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  sefc_in_if.sink           in_ch,
  sefc_out_if.source        out_ch
);
  import sefc_pkg::*;

  push_t   push;
  logic    room;
  result_t head;

  sefc_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_rx_byte   (in_ch.rx_byte),
    .in_chunk_end (in_ch.chunk_end),
    .room         (room),
    .push         (push)
  );

  sefc_out_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (head)
  );

  // Result beat fields
  assign out_ch.kind         = head.kind;
  assign out_ch.frame_cmd    = head.frame_cmd;
  assign out_ch.payload_byte = head.payload_byte;
  assign out_ch.status       = head.status;
  assign out_ch.last         = head.last;

endmodule

`default_nettype wire

[design/sefc_parser.sv]
`default_nettype none

module sefc_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_rx_byte,
  input  logic           in_chunk_end,
  input  logic           room,
  output sefc_pkg::push_t push
);
  import sefc_pkg::*;

  `include "assert_macros.svh"

  // Input register
  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       end_r;
  logic       step;

  // Frame state
  phase_t      phase_r, phase_nxt;
  logic        smo_r, smo_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  lenh_r, lenh_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  rcv_r, rcv_nxt;

  logic        pay_vld, stat_vld;
  status_t     stat_code;
  result_t     pay_item, stat_item;

  // Byte is parsed once the queue can take both possible results
  assign step     = in_vld_r && room;
  assign in_ready = !in_vld_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_rx_byte;
      end_r  <= in_chunk_end;
    end
  end

  // Next state for one byte
  always_comb begin
    phase_nxt = phase_r;
    smo_nxt   = smo_r;
    cmd_nxt   = cmd_r;
    lenh_nxt  = lenh_r;
    left_nxt  = left_r;
    sum_nxt   = sum_r;
    rcv_nxt   = rcv_r;
    pay_vld   = 1'b0;
    stat_vld  = 1'b0;
    stat_code = ST_OK;
    case (phase_r)
      PH_STX: begin
        smo_nxt   = (byte_r == MARK_START);
        cmd_nxt   = '0;
        sum_nxt   = '0;
        phase_nxt = PH_CMD;
      end
      PH_CMD: begin
        cmd_nxt   = byte_r;
        sum_nxt   = byte_r;
        phase_nxt = PH_LENH;
      end
      PH_LENH: begin
        lenh_nxt  = byte_r;
        sum_nxt   = sum_r + byte_r;
        phase_nxt = PH_LENL;
      end
      PH_LENL: begin
        sum_nxt   = sum_r + byte_r;
        left_nxt  = {lenh_r, byte_r};
        phase_nxt = ({lenh_r, byte_r} == 16'd0) ? PH_SUM : PH_PAY;
      end
      PH_PAY: begin
        sum_nxt  = sum_r + byte_r;
        pay_vld  = 1'b1;
        left_nxt = left_r - 16'd1;
        if (left_r == 16'd1) begin
          phase_nxt = PH_SUM;
        end
      end
      PH_SUM: begin
        rcv_nxt   = byte_r;
        phase_nxt = PH_ETX;
      end
      PH_ETX: begin
        stat_vld = 1'b1;
        if (!smo_r || byte_r != MARK_END) begin
          stat_code = ST_MARK;
        end else if (rcv_r != sum_r) begin
          stat_code = ST_CSUM;
        end else begin
          stat_code = ST_OK;
        end
        phase_nxt = end_r ? PH_STX : PH_DROP;
      end
      PH_DROP: begin
        if (end_r) begin
          phase_nxt = PH_STX;
        end
      end
      default: begin
        phase_nxt = PH_STX;
      end
    endcase
    // Chunk ended before the ETX position
    if (end_r && !(phase_r inside {PH_ETX, PH_DROP})) begin
      stat_vld  = 1'b1;
      stat_code = ST_SHORT;
      phase_nxt = PH_STX;
    end
  end

  // Result beats; a payload beat goes ahead of a status beat
  always_comb begin
    pay_item              = '0;
    pay_item.kind         = KIND_PAYLOAD;
    pay_item.frame_cmd    = cmd_nxt;
    pay_item.payload_byte = byte_r;
    pay_item.status       = ST_OK;
    stat_item             = '0;
    stat_item.kind        = KIND_STATUS;
    stat_item.frame_cmd   = cmd_nxt;
    stat_item.status      = stat_code;
    stat_item.last        = 1'b1;

    push.vld0  = step && (pay_vld || stat_vld);
    push.vld1  = step && pay_vld && stat_vld;
    push.item0 = pay_vld ? pay_item : stat_item;
    push.item1 = stat_item;
  end

  // State update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_STX;
      smo_r   <= 1'b0;
      cmd_r   <= '0;
      lenh_r  <= '0;
      left_r  <= '0;
      sum_r   <= '0;
      rcv_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      smo_r   <= smo_nxt;
      cmd_r   <= cmd_nxt;
      lenh_r  <= lenh_nxt;
      left_r  <= left_nxt;
      sum_r   <= sum_nxt;
      rcv_r   <= rcv_nxt;
    end
  end

  // Checks
  `AST_IMPLY(a_pair_order, push.vld1,
             push.vld0 && push.item0.kind == KIND_PAYLOAD && push.item1.last,
             "second beat must be a status following a payload beat")
  `AST_IMPLY(a_etx_status, step && phase_r == PH_ETX,
             push.vld0 && push.item0.last && !push.vld1,
             "ETX position must close the frame with one status beat")
  `AST_IMPLY(a_pay_count, phase_r == PH_PAY, left_r != 16'd0,
             "payload phase entered with no bytes left")

endmodule

`default_nettype wire

[design/sefc_out_queue.sv]
`default_nettype none

module sefc_out_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sefc_pkg::push_t  push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output sefc_pkg::result_t out_item
);
  import sefc_pkg::*;

  `include "assert_macros.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  result_t       mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == LAST_IDX) ? '0 : p + PW'(1);
  endfunction

  assign room      = (cnt_r <= ROOM_MAX);
  assign out_valid = (cnt_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push.vld1) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_p1);
    end else if (push.vld0) begin
      wr_ptr_nxt = wr_ptr_p1;
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push.vld0) + CW'(push.vld1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry writes
  always_ff @(posedge clk) begin
    if (push.vld0) begin
      mem_r[wr_ptr_r] <= push.item0;
    end
    if (push.vld1) begin
      mem_r[wr_ptr_p1] <= push.item1;
    end
  end

  // Checks
  `AST_ALWAYS(a_cnt_range, cnt_r <= FULL_CNT, "result queue count beyond depth")
  `AST_IMPLY(a_push_room, push.vld0, room, "result pushed without two free slots")

endmodule

`default_nettype wire

[test/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sefc_pkg::*;

  localparam int unsigned RANDOM_BEATS = 950;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 12;

  // Ways a random frame gets damaged
  typedef enum int unsigned {
    FL_CLEAN,
    FL_BAD_SUM,
    FL_BAD_STX,
    FL_BAD_ETX,
    FL_CUT,
    FL_TRAIL
  } flaw_t;

  // One directed beat; typed rows carry the status item expected at this byte
  typedef struct packed {
    logic [7:0] rx;
    logic       ce;
    logic       typed;
    status_t    st;
    logic [7:0] cmd;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  sefc_in_if  in_bus ();
  sefc_out_if out_bus ();

  stx_etx_frame_checker_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always #5 clk = ~clk;

  // Frame parser state mirrored by the testbench
  phase_t      fp_phase    = PH_STX;
  logic        fp_start_ok = 1'b0;
  logic [7:0]  fp_cmd      = '0;
  logic [7:0]  fp_len_hi   = '0;
  logic [15:0] fp_left     = '0;
  logic [7:0]  fp_sum      = '0;
  logic [7:0]  fp_rx_sum   = '0;

  result_t     awaited_results[$];
  int unsigned fail_count = 0;
  int unsigned sent_beats = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_mode = 0;
  result_t     want;
  stim_row_t   directed_rows [0:26];

  function automatic result_t frame_result(input logic kind, input logic [7:0] pay,
                                           input status_t st);
    result_t r;
    r.kind         = kind;
    r.frame_cmd    = fp_cmd;
    r.payload_byte = pay;
    r.status       = st;
    r.last         = kind;
    return r;
  endfunction

  // Advance the parser by one accepted byte and queue the results it causes
  task automatic frame_parse_step(input logic [7:0] rx, input logic ce);
    logic    closed;
    status_t st;
    closed = 1'b0;
    case (fp_phase)
      PH_STX: begin
        fp_start_ok = (rx == MARK_START);
        fp_cmd      = '0;
        fp_sum      = '0;
        fp_phase    = PH_CMD;
      end
      PH_CMD: begin
        fp_cmd   = rx;
        fp_sum   = rx;
        fp_phase = PH_LENH;
      end
      PH_LENH: begin
        fp_len_hi = rx;
        fp_sum    = fp_sum + rx;
        fp_phase  = PH_LENL;
      end
      PH_LENL: begin
        fp_sum   = fp_sum + rx;
        fp_left  = {fp_len_hi, rx};
        fp_phase = (fp_left == '0) ? PH_SUM : PH_PAY;
      end
      PH_PAY: begin
        fp_sum = fp_sum + rx;
        awaited_results.push_back(frame_result(KIND_PAYLOAD, rx, ST_OK));
        fp_left = fp_left - 16'd1;
        if (fp_left == '0) fp_phase = PH_SUM;
      end
      PH_SUM: begin
        fp_rx_sum = rx;
        fp_phase  = PH_ETX;
      end
      PH_ETX: begin
        // marker errors outrank a checksum mismatch
        if (!fp_start_ok || rx != MARK_END) st = ST_MARK;
        else if (fp_rx_sum != fp_sum) st = ST_CSUM;
        else st = ST_OK;
        awaited_results.push_back(frame_result(KIND_STATUS, 8'h00, st));
        fp_phase = ce ? PH_STX : PH_DROP;
        closed   = 1'b1;
      end
      default: begin
        // trailing bytes are dropped until the chunk ends
        if (ce) fp_phase = PH_STX;
        closed = 1'b1;
      end
    endcase
    // chunk ended before the ETX position
    if (!closed && ce) begin
      awaited_results.push_back(frame_result(KIND_STATUS, 8'h00, ST_SHORT));
      fp_phase = PH_STX;
    end
  endtask

  // Drive one beat and wait for it to be taken
  task automatic drive_beat(input logic [7:0] rx, input logic ce);
    in_bus.valid     <= 1'b1;
    in_bus.rx_byte   <= rx;
    in_bus.chunk_end <= ce;
    do @(posedge clk); while (!in_bus.ready);
    frame_parse_step(rx, ce);
    sent_beats++;
  endtask

  // Idle between bursts
  task automatic burst_gap();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 5);
      in_bus.valid     <= 1'b0;
      in_bus.rx_byte   <= 8'($urandom_range(0, 255));
      in_bus.chunk_end <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 8);
    end
  endtask

  // Drive one beat, then idle between bursts
  task automatic send_beat(input logic [7:0] rx, input logic ce);
    drive_beat(rx, ce);
    burst_gap();
  endtask

  // Hold the sender off until every queued result has come out
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // Well-formed frame with random content, possibly damaged
  task automatic send_random_frame(input bit force_long);
    logic [7:0]  frame_bytes[$];
    logic [7:0]  csum;
    int unsigned len;
    int unsigned pick;
    int unsigned cut;
    int unsigned n_trail;
    flaw_t       flaw;
    pick = $urandom_range(0, 99);
    if (force_long || pick == 0) len = 256 + $urandom_range(0, 3);
    else if (pick < 15) len = 0;
    else len = $urandom_range(1, 12);
    pick = $urandom_range(0, 9);
    flaw = (pick < 5) ? FL_CLEAN : flaw_t'(pick - 4);

    frame_bytes.push_back(MARK_START);
    frame_bytes.push_back(8'($urandom_range(0, 255)));
    frame_bytes.push_back(len[15:8]);
    frame_bytes.push_back(len[7:0]);
    for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
    csum = '0;
    for (int i = 1; i < frame_bytes.size(); i++) csum = csum + frame_bytes[i];
    if (flaw == FL_BAD_SUM) csum = csum ^ 8'($urandom_range(1, 255));
    frame_bytes.push_back(csum);
    frame_bytes.push_back(MARK_END);

    if (flaw == FL_BAD_STX) frame_bytes[0] = MARK_START ^ 8'($urandom_range(1, 255));
    if (flaw == FL_BAD_ETX)
      frame_bytes[frame_bytes.size()-1] = MARK_END ^ 8'($urandom_range(1, 255));
    if (flaw == FL_CUT) begin
      cut = $urandom_range(0, frame_bytes.size() - 2);
      while (frame_bytes.size() > cut + 1) void'(frame_bytes.pop_back());
    end
    n_trail = (flaw == FL_TRAIL) ? $urandom_range(1, 4) : 0;

    for (int i = 0; i < frame_bytes.size(); i++)
      send_beat(frame_bytes[i], (i == frame_bytes.size() - 1) && (n_trail == 0));
    for (int k = 0; k < n_trail; k++)
      send_beat(8'($urandom_range(0, 255)), k == n_trail - 1);
  endtask

  // Random bytes with random chunk ends, last one closes the chunk
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 10);
    for (int k = 0; k < n; k++)
      send_beat(8'($urandom_range(0, 255)), (k == n - 1) || ($urandom_range(0, 3) == 0));
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing expected: kind=%0h status=%0h",
               out_bus.kind, out_bus.status);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", 8'(want.kind), 8'(out_bus.kind));
        check_field("frame_cmd", want.frame_cmd, out_bus.frame_cmd);
        check_field("payload_byte", want.payload_byte, out_bus.payload_byte);
        check_field("status", 8'(want.status), 8'(out_bus.status));
        check_field("last", 8'(want.last), 8'(out_bus.last));
      end
    end
  end

  // Receiver stall pattern and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 50 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_bus.ready <= 1'b1;
      1:       out_bus.ready <= 1'($urandom_range(0, 1));
      2:       out_bus.ready <= (cycle_count[1:0] == 2'd0);
      default: out_bus.ready <= (cycle_count[3:0] >= 4'd10);
    endcase
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run limit reached with %0d results outstanding", awaited_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    bit paused;
    result_t typed_res;
    paused = 1'b0;
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.rx_byte   <= '0;
    in_bus.chunk_end <= 1'b0;

    directed_rows = '{
      // chunk ends on its first byte: short, no command yet
      '{8'h00,      1'b1, 1'b1, ST_SHORT, 8'h00},
      // zero-length frame, all-ones command, good checksum
      '{MARK_START, 1'b0, 1'b0, ST_OK,    8'h00},
      '{8'hFF,      1'b0, 1'b0, ST_OK,    8'h00},
      '{8'h00,      1'b0, 1'b0, ST_OK,    8'h00},
      '{8'h00,      1'b0, 1'b0, ST_OK,    8'h00},
      '{8'hFF,      1'b0, 1'b0, ST_OK,    8'h00},
      '{MARK_END,   1'b1, 1'b1, ST_OK,    8'hFF},
      // two payload bytes, checksum off by one, one trailing byte
      '{MARK_START, 1'b0, 1'b0, ST_OK,    8'h00},
      '{8'h10,      1'b0, 1'b0, ST_OK,    8'h00},
      '{8'h00,      1'b0, 1'b0, ST_OK,    8'h00},
      '{8'h02,      1'b0, 1'b0, ST_OK,    8'h00},
      '{8'hFF,      1'b0, 1'b0, ST_OK,    8'h00},
      '{8'h00,      1'b0, 1'b0, ST_OK,    8'h00},
      '{8'h12,      1'b0, 1'b0, ST_OK,    8'h00},
      '{MARK_END,   1'b0, 1'b1, ST_CSUM,  8'h10},
      '{8'h55,      1'b1, 1'b0, ST_OK,    8'h00},
      // wrong start marker
      '{8'hFF,      1'b0, 1'b0, ST_OK,    8'h00},
      '{8'h01,      1'b0, 1'b0, ST_OK,    8'h00},
      '{8'h00,      1'b0, 1'b0, ST_OK,    8'h00},
      '{8'h00,      1'b0, 1'b0, ST_OK,    8'h00},
      '{8'h01,      1'b0, 1'b0, ST_OK,    8'h00},
      '{MARK_END,   1'b1, 1'b1, ST_MARK,  8'h01},
      // chunk ends on a payload byte: payload beat, then short
      '{MARK_START, 1'b0, 1'b0, ST_OK,    8'h00},
      '{8'h80,      1'b0, 1'b0, ST_OK,    8'h00},
      '{8'h00,      1'b0, 1'b0, ST_OK,    8'h00},
      '{8'h05,      1'b0, 1'b0, ST_OK,    8'h00},
      '{8'h7F,      1'b1, 1'b1, ST_SHORT, 8'h80}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part; typed expectation replaces the predicted one right away
    foreach (directed_rows[i]) begin
      drive_beat(directed_rows[i].rx, directed_rows[i].ce);
      if (directed_rows[i].typed) begin
        typed_res.kind         = KIND_STATUS;
        typed_res.frame_cmd    = directed_rows[i].cmd;
        typed_res.payload_byte = 8'h00;
        typed_res.status       = directed_rows[i].st;
        typed_res.last         = 1'b1;
        awaited_results[awaited_results.size()-1] = typed_res;
      end
      burst_gap();
    end

    // Random part: mostly frames, some line noise
    sent_beats = 0;
    send_random_frame(1'b1);
    while (sent_beats < RANDOM_BEATS) begin
      if ($urandom_range(0, 9) < 8) send_random_frame(1'b0);
      else send_noise();
      if (!paused && sent_beats >= RANDOM_BEATS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
